>>> rtl/core/clfd_pkg.sv
// Package for the channel load fault detector: payload structs, fault and
// register index codes, field widths, reset values and default parameters.
// No dependencies.
package clfd_pkg;

    // Default values of the top-level parameters.
    localparam int CHANNELS_DEF   = 4;
    localparam int ADC_BITS_DEF   = 12;
    localparam int VREF_MV_DEF    = 3300;
    localparam int SHUNT_MOHM_DEF = 100;
    localparam int AMP_GAIN_DEF   = 50;

    // Fixed field widths.
    localparam int ADC_W      = 12;
    localparam int MA_W       = 12;
    localparam int CNT_W      = 8;
    localparam int MV_W       = 16;
    localparam int CH_W       = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MA_MAX         = 4095;
    localparam int MILLI_PER_UNIT = 1000;

    // Register reset values.
    localparam logic [MA_W-1:0]  SHORT_THR_RST   = 12'd2000;
    localparam logic [MA_W-1:0]  OPEN_THR_RST    = 12'd10;
    localparam logic [CNT_W-1:0] DEBOUNCE_RST    = 8'd3;
    localparam logic [MV_W-1:0]  OPEN_MIN_MV_RST = 16'd500;

    // Transaction function codes.
    localparam logic FUNC_CHECK = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_OPEN  = 2'd2
    } t_fault_kind;

    typedef enum logic [1:0] {
        CFG_SHORT_THR   = 2'd0,
        CFG_OPEN_THR    = 2'd1,
        CFG_DEBOUNCE    = 2'd2,
        CFG_OPEN_MIN_MV = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic             func;
        logic [CH_W-1:0]  channel;
        logic [ADC_W-1:0] adc_raw;
        logic             chan_enabled;
        logic [MV_W-1:0]  setpoint_mv;
    } t_in_item;

    typedef struct packed {
        logic            fault_raised;
        t_fault_kind     fault_kind;
        logic [MA_W-1:0] measured_ma;
        logic            any_fault;
        logic [CH_W-1:0] out_channel;
    } t_out_item;

endpackage

>>> rtl/core/channel_load_fault_detector.sv
// Channel load fault detector: current conversion pipeline followed by the
// per-channel short/open debounce and fault latch.
// Depends on clfd_pkg.
//
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_stall     i_in_data  (t_in_item)
//  result    out        o_out_valid / i_out_stall   o_out_data (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One transaction is accepted per cycle while o_in_stall is low; its result passes
// through the conversion pipeline (input register, scale by the reference,
// reciprocal multiply, scale to milliamps, reciprocal multiply) and the
// result register, where the channel state update is done.
// Reset is synchronous: it clears all channel state and pipeline valids and
// returns the registers to their defaults. A stalled result holds while the
// stages behind it keep filling, so bubbles close up before o_in_stall rises.
module channel_load_fault_detector #(
    parameter int CHANNELS        = clfd_pkg::CHANNELS_DEF,
    parameter int ADC_BITS        = clfd_pkg::ADC_BITS_DEF,
    parameter int VREF_MILLIVOLTS = clfd_pkg::VREF_MV_DEF,
    parameter int SHUNT_MILLIOHM  = clfd_pkg::SHUNT_MOHM_DEF,
    parameter int AMP_GAIN        = clfd_pkg::AMP_GAIN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  clfd_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output clfd_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  clfd_pkg::t_cfg_index                i_cfg_index,
    input  logic [clfd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import clfd_pkg::*;

    // Millivolts: floor(raw * VREF / (2^ADC_BITS - 1)) by exact reciprocal.
    localparam int D1  = (1 << ADC_BITS) - 1;
    localparam int XW  = ADC_W + $clog2(VREF_MILLIVOLTS + 1);
    localparam int S1  = XW + $clog2(D1);
    localparam longint unsigned M1 =
        ((64'd1 << S1) + longint'(D1) - 64'd1) / longint'(D1);
    localparam int M1W = XW + 2;
    localparam int P1W = XW + M1W;
    localparam longint MV_MAX = (longint'((1 << ADC_W) - 1) * VREF_MILLIVOLTS) / D1;
    localparam int MVW = $clog2(MV_MAX + 1);

    // Milliamps: floor(mv * 1000 / (shunt * gain)) by exact reciprocal.
    localparam int YW  = MVW + 10;
    localparam int D2  = SHUNT_MILLIOHM * AMP_GAIN;
    localparam int S2  = YW + $clog2(D2);
    localparam longint unsigned M2 =
        ((64'd1 << S2) + longint'(D2) - 64'd1) / longint'(D2);
    localparam int M2W = YW + 2;
    localparam int P2W = YW + M2W;

    localparam int NST = 5;

    // Configuration registers.
    logic [MA_W-1:0]  r_short_thr;
    logic [MA_W-1:0]  r_open_thr;
    logic [CNT_W-1:0] r_debounce;
    logic [MV_W-1:0]  r_open_min;

    // Pipeline.
    logic [NST-1:0]   r_v;
    logic [NST-1:0]   go;
    t_in_item         r_it [NST];
    logic [XW-1:0]    r_x1;
    logic [MVW-1:0]   r_mv;
    logic [YW-1:0]    r_y;
    logic [MA_W-1:0]  r_ma;
    logic             out_free;
    logic             accept;

    logic [P1W-1:0]   prod1;
    logic [P2W-1:0]   prod2;
    logic [P2W-1:0]   quot2;
    logic [MVW-1:0]   n_mv;
    logic [YW-1:0]    n_y;
    logic [MA_W-1:0]  n_ma;

    // Channel state.
    t_fault_kind      r_kind    [CHANNELS];
    logic [CNT_W-1:0] r_sc      [CHANNELS];
    logic [CNT_W-1:0] r_oc      [CHANNELS];
    logic [CHANNELS-1:0] r_active;
    logic [CHANNELS-1:0] r_latched;

    t_fault_kind      n_kind    [CHANNELS];
    logic [CNT_W-1:0] n_sc      [CHANNELS];
    logic [CNT_W-1:0] n_oc      [CHANNELS];
    logic [CHANNELS-1:0] n_active;
    logic [CHANNELS-1:0] n_latched;

    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    function automatic logic [CNT_W-1:0] f_bump(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    // ---------------------------------------------------------------- handshake
    always_comb begin
        out_free      = !r_out_valid || !i_out_stall;
        go[NST-1]     = r_v[NST-1] && out_free;
        for (int k = NST - 2; k >= 0; k--) begin
            go[k] = r_v[k] && (!r_v[k+1] || go[k+1]);
        end
    end

    assign o_in_stall  = r_v[0] && !go[0];
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_v[0] <= 1'b1;
            end else if (go[0]) begin
                r_v[0] <= 1'b0;
            end
            for (int k = 1; k < NST; k++) begin
                if (go[k-1]) begin
                    r_v[k] <= 1'b1;
                end else if (go[k]) begin
                    r_v[k] <= 1'b0;
                end
            end
            if (go[NST-1]) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_thr <= SHORT_THR_RST;
            r_open_thr  <= OPEN_THR_RST;
            r_debounce  <= DEBOUNCE_RST;
            r_open_min  <= OPEN_MIN_MV_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SHORT_THR:   r_short_thr <= i_cfg_data[MA_W-1:0];
                CFG_OPEN_THR:    r_open_thr  <= i_cfg_data[MA_W-1:0];
                CFG_DEBOUNCE:    r_debounce  <= i_cfg_data[CNT_W-1:0];
                CFG_OPEN_MIN_MV: r_open_min  <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- conversion
    always_comb begin
        prod1 = P1W'(r_x1) * P1W'(M1W'(M1));
        n_mv  = MVW'(prod1 >> S1);
        n_y   = YW'(r_mv) * YW'(MILLI_PER_UNIT);
        prod2 = P2W'(r_y) * P2W'(M2W'(M2));
        quot2 = prod2 >> S2;
        n_ma  = (quot2 > P2W'(MA_MAX)) ? MA_W'(MA_MAX) : MA_W'(quot2);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_it[0] <= i_in_data;
        end
        if (go[0]) begin
            r_it[1] <= r_it[0];
            r_x1    <= XW'(r_it[0].adc_raw) * XW'(VREF_MILLIVOLTS);
        end
        if (go[1]) begin
            r_it[2] <= r_it[1];
            r_mv    <= n_mv;
        end
        if (go[2]) begin
            r_it[3] <= r_it[2];
            r_y     <= n_y;
        end
        if (go[3]) begin
            r_it[4] <= r_it[3];
            r_ma    <= n_ma;
        end
    end

    // ---------------------------------------------------------- channel state
    always_comb begin
        logic is_short;
        logic is_open;
        logic hit;
        is_short = r_ma > r_short_thr;
        is_open  = (r_it[4].setpoint_mv > r_open_min) && (r_ma < r_open_thr);

        n_out.fault_raised = 1'b0;
        n_out.fault_kind   = KIND_NONE;
        n_out.measured_ma  = (r_it[4].func == FUNC_CLEAR) ? '0 : r_ma;
        n_out.out_channel  = r_it[4].channel;

        for (int c = 0; c < CHANNELS; c++) begin
            hit          = (int'(r_it[4].channel) == c);
            n_kind[c]    = r_kind[c];
            n_sc[c]      = r_sc[c];
            n_oc[c]      = r_oc[c];
            n_active[c]  = r_active[c];
            n_latched[c] = r_latched[c];
            if (hit) begin
                if (r_it[4].func == FUNC_CLEAR) begin
                    n_kind[c]    = KIND_NONE;
                    n_sc[c]      = '0;
                    n_oc[c]      = '0;
                    n_active[c]  = 1'b0;
                    n_latched[c] = 1'b0;
                end else if (!r_it[4].chan_enabled) begin
                    n_sc[c] = '0;
                    n_oc[c] = '0;
                end else if (is_short) begin
                    n_sc[c] = f_bump(r_sc[c]);
                    n_oc[c] = '0;
                    if (n_sc[c] >= r_debounce && r_kind[c] != KIND_SHORT) begin
                        n_kind[c]          = KIND_SHORT;
                        n_active[c]        = 1'b1;
                        n_latched[c]       = 1'b1;
                        n_out.fault_raised = 1'b1;
                    end
                end else if (is_open) begin
                    n_oc[c] = f_bump(r_oc[c]);
                    n_sc[c] = '0;
                    if (n_oc[c] >= r_debounce && r_kind[c] != KIND_OPEN) begin
                        n_kind[c]          = KIND_OPEN;
                        n_active[c]        = 1'b1;
                        n_latched[c]       = 1'b1;
                        n_out.fault_raised = 1'b1;
                    end
                end else begin
                    n_sc[c] = '0;
                    n_oc[c] = '0;
                    // An unlatched fault goes away once the load looks normal.
                    if (r_active[c] && !r_latched[c]) begin
                        n_kind[c]   = KIND_NONE;
                        n_active[c] = 1'b0;
                    end
                end
                n_out.fault_kind = n_kind[c];
            end
        end
        n_out.any_fault = |n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_kind[c] <= KIND_NONE;
                r_sc[c]   <= '0;
                r_oc[c]   <= '0;
            end
            r_active  <= '0;
            r_latched <= '0;
        end else if (go[NST-1]) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_kind[c] <= n_kind[c];
                r_sc[c]   <= n_sc[c];
                r_oc[c]   <= n_oc[c];
            end
            r_active  <= n_active;
            r_latched <= n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[NST-1]) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_raised_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fault_raised) |->
            (r_out.any_fault && r_out.fault_kind != KIND_NONE))
        else $error("new fault reported without an active fault");

    for (genvar g = 0; g < CHANNELS; g++) begin : g_chk
        a_one_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            !(r_sc[g] != '0 && r_oc[g] != '0))
            else $error("short and open counters both running on one channel");

        a_active_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_active[g] == (r_kind[g] != KIND_NONE))
            else $error("active flag disagrees with the stored fault kind");

        a_latched_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_latched[g] |-> r_active[g])
            else $error("latched fault without an active flag");
    end
`endif

endmodule

>>> sim/channel_load_fault_detector_tb.sv
// Self-checking testbench for channel_load_fault_detector: short/open debounce,
// fault latching, clears and limit register settings under random idling.
// Depends on clfd_pkg and the channel_load_fault_detector RTL.
`timescale 1ns / 100ps

module channel_load_fault_detector_tb;

    import clfd_pkg::*;

    localparam int CHANNELS = CHANNELS_DEF;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_index            i_cfg_index = CFG_SHORT_THR;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    channel_load_fault_detector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Limit settings as the block should currently hold them.
    logic [MA_W-1:0]  short_thr_ma  = SHORT_THR_RST;
    logic [MA_W-1:0]  open_thr_ma   = OPEN_THR_RST;
    logic [CNT_W-1:0] debounce_need = DEBOUNCE_RST;
    logic [MV_W-1:0]  open_arm_mv   = OPEN_MIN_MV_RST;

    // Per-channel detector state mirrored from the accepted transactions.
    t_fault_kind      chan_fault   [CHANNELS] = '{default: KIND_NONE};
    logic [CNT_W-1:0] short_run    [CHANNELS] = '{default: '0};
    logic [CNT_W-1:0] open_run     [CHANNELS] = '{default: '0};
    bit               chan_active  [CHANNELS] = '{default: 1'b0};
    bit               chan_latched [CHANNELS] = '{default: 1'b0};

    t_in_item  pending_samples[$];
    t_out_item expected_results[$];
    int        error_count  = 0;
    int        gap_left     = 0;
    int        stall_left   = 0;
    bit        calm_inputs  = 1'b0;
    bit        calm_outputs = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic t_in_item mk_item(input logic func, input int ch, input int raw,
                                         input logic en, input int target);
        t_in_item it;
        it.func         = func;
        it.channel      = CH_W'(ch);
        it.adc_raw      = ADC_W'(raw);
        it.chan_enabled = en;
        it.setpoint_mv  = MV_W'(target);
        return it;
    endfunction

    function automatic t_out_item predict_load_check(input t_in_item it);
        t_out_item         res;
        longint unsigned   mv;
        longint unsigned   ma;
        int unsigned       ch;
        bit                any;
        res = '0;
        ma  = 0;
        any = 1'b0;
        ch  = 32'(it.channel);
        if (it.func == FUNC_CHECK) begin
            mv = (longint'(it.adc_raw) * VREF_MV_DEF) / ((64'd1 << ADC_BITS_DEF) - 1);
            ma = (mv * MILLI_PER_UNIT) / (SHUNT_MOHM_DEF * AMP_GAIN_DEF);
            if (ma > MA_MAX) ma = 64'(MA_MAX);
        end
        if (ch < CHANNELS) begin
            if (it.func == FUNC_CLEAR) begin
                chan_fault[ch]   = KIND_NONE;
                short_run[ch]    = '0;
                open_run[ch]     = '0;
                chan_active[ch]  = 1'b0;
                chan_latched[ch] = 1'b0;
            end else if (!it.chan_enabled) begin
                short_run[ch] = '0;
                open_run[ch]  = '0;
            end else if (ma > short_thr_ma) begin
                if (short_run[ch] != '1) short_run[ch]++;
                open_run[ch] = '0;
                if (short_run[ch] >= debounce_need && chan_fault[ch] != KIND_SHORT) begin
                    chan_fault[ch]   = KIND_SHORT;
                    chan_active[ch]  = 1'b1;
                    chan_latched[ch] = 1'b1;
                    res.fault_raised = 1'b1;
                end
            end else if (it.setpoint_mv > open_arm_mv && ma < open_thr_ma) begin
                if (open_run[ch] != '1) open_run[ch]++;
                short_run[ch] = '0;
                if (open_run[ch] >= debounce_need && chan_fault[ch] != KIND_OPEN) begin
                    chan_fault[ch]   = KIND_OPEN;
                    chan_active[ch]  = 1'b1;
                    chan_latched[ch] = 1'b1;
                    res.fault_raised = 1'b1;
                end
            end else begin
                short_run[ch] = '0;
                open_run[ch]  = '0;
                if (chan_active[ch] && !chan_latched[ch]) begin
                    chan_fault[ch]  = KIND_NONE;
                    chan_active[ch] = 1'b0;
                end
            end
            res.fault_kind = chan_fault[ch];
        end
        for (int c = 0; c < CHANNELS; c++) begin
            if (chan_active[c]) any = 1'b1;
        end
        res.measured_ma = ma[MA_W-1:0];
        res.any_fault   = any;
        res.out_channel = it.channel;
        return res;
    endfunction

    // Mostly short pauses, with the occasional long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge i_clk) begin : drive_samples
        logic     next_valid;
        t_in_item next_data;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            next_valid = i_in_valid;
            next_data  = i_in_data;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_load_check(i_in_data));
                next_valid = 1'b0;
                gap_left = (calm_inputs || $urandom_range(0, 2) != 0) ? 0 : pick_pause();
            end
            if (!next_valid && pending_samples.size() != 0) begin
                if (gap_left == 0) begin
                    next_data  = pending_samples.pop_front();
                    next_valid = 1'b1;
                end else begin
                    gap_left--;
                end
            end
            i_in_valid <= next_valid;
            i_in_data  <= next_data;
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_out_item want;
        logic      next_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result for ch%0d with nothing outstanding",
                                              o_out_data.out_channel));
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.fault_raised !== want.fault_raised)
                        report_mismatch($sformatf("ch%0d fault_raised got %0d expected %0d",
                            want.out_channel, o_out_data.fault_raised, want.fault_raised));
                    if (o_out_data.fault_kind !== want.fault_kind)
                        report_mismatch($sformatf("ch%0d fault_kind got %0d expected %0d",
                            want.out_channel, o_out_data.fault_kind, want.fault_kind));
                    if (o_out_data.measured_ma !== want.measured_ma)
                        report_mismatch($sformatf("ch%0d measured_ma got %0d expected %0d",
                            want.out_channel, o_out_data.measured_ma, want.measured_ma));
                    if (o_out_data.any_fault !== want.any_fault)
                        report_mismatch($sformatf("ch%0d any_fault got %0d expected %0d",
                            want.out_channel, o_out_data.any_fault, want.any_fault));
                    if (o_out_data.out_channel !== want.out_channel)
                        report_mismatch($sformatf("out_channel got %0d expected %0d",
                            o_out_data.out_channel, want.out_channel));
                end
            end
            if (stall_left > 0) begin
                next_stall = 1'b1;
                stall_left--;
            end else if (!calm_outputs && $urandom_range(0, 5) == 0) begin
                next_stall = 1'b1;
                stall_left = pick_pause() - 1;
            end else begin
                next_stall = 1'b0;
            end
            i_out_stall <= next_stall;
        end
    end

    // Checked at the falling edge, when the driver's updates have all settled;
    // returns at a rising edge.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || expected_results.size() != 0);
        @(posedge i_clk);
    endtask

    // Called at a rising edge; leaves the write channel valid for a following write.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_SHORT_THR:   short_thr_ma  = data[MA_W-1:0];
            CFG_OPEN_THR:    open_thr_ma   = data[MA_W-1:0];
            CFG_DEBOUNCE:    debounce_need = data[CNT_W-1:0];
            CFG_OPEN_MIN_MV: open_arm_mv   = data[MV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input int short_v, input int open_v, input int deb_v,
                              input int min_v);
        wait_drained();
        write_reg(CFG_SHORT_THR, CFG_DATA_W'(short_v));
        write_reg(CFG_OPEN_THR, CFG_DATA_W'(open_v));
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb_v));
        write_reg(CFG_OPEN_MIN_MV, CFG_DATA_W'(min_v));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Runs of like samples on one channel, so that the debounce counters really
    // climb, broken now and then by a stray transaction.
    task automatic queue_random(input int count);
        int   made;
        int   len;
        int   kind;
        int   ch;
        int   ich;
        int   raw;
        int   target;
        int   lo;
        logic func;
        logic en;
        made = 0;
        while (made < count) begin
            ch   = $urandom_range(0, CHANNELS - 1);
            kind = $urandom_range(0, 99);
            if (debounce_need >= 200 && $urandom_range(0, 1) == 1)
                len = $urandom_range(250, 300);
            else
                len = $urandom_range(1, debounce_need < 8 ? debounce_need + 3 : 10);
            for (int i = 0; i < len; i++) begin
                func   = FUNC_CHECK;
                en     = 1'b1;
                ich    = ch;
                raw    = $urandom_range(0, 4095);
                target = $urandom_range(0, 65535);
                if ($urandom_range(0, 19) == 0 || kind >= 92) begin
                    func = 1'($urandom_range(0, 1));
                    en   = 1'($urandom_range(0, 1));
                    ich  = $urandom_range(0, 3);
                end else if (kind < 35) begin
                    raw = 4095 - $urandom_range(0, 600);
                end else if (kind < 65) begin
                    raw = $urandom_range(0, 60);
                    lo  = open_arm_mv + 1;
                    target = $urandom_range(lo > 65535 ? 65535 : lo, 65535);
                end else if (kind >= 78 && kind < 86) begin
                    en = 1'b0;
                end else if (kind >= 86) begin
                    func = FUNC_CLEAR;
                end
                pending_samples.push_back(mk_item(func, ich, raw, en, target));
                made++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default limits: open fault on channel 0, no short reachable.
        pending_samples.push_back(mk_item(FUNC_CHECK, 0, 0, 1'b1, 65535));
        pending_samples.push_back(mk_item(FUNC_CHECK, 0, 0, 1'b1, 65535));
        pending_samples.push_back(mk_item(FUNC_CHECK, 0, 0, 1'b1, 65535));
        pending_samples.push_back(mk_item(FUNC_CHECK, 0, 0, 1'b1, 65535));
        pending_samples.push_back(mk_item(FUNC_CHECK, 1, 4095, 1'b1, 0));
        pending_samples.push_back(mk_item(FUNC_CHECK, 2, 4095, 1'b0, 65535));
        pending_samples.push_back(mk_item(FUNC_CHECK, 0, 0, 1'b1, 500));
        pending_samples.push_back(mk_item(FUNC_CLEAR, 0, 4095, 1'b1, 65535));
        pending_samples.push_back(mk_item(FUNC_CLEAR, 3, 0, 1'b0, 0));

        // Short replaced by open, disabled channel restarting the count.
        set_limits(600, 100, 2, 1000);
        pending_samples.push_back(mk_item(FUNC_CHECK, 3, 4095, 1'b1, 0));
        pending_samples.push_back(mk_item(FUNC_CHECK, 3, 4095, 1'b1, 0));
        pending_samples.push_back(mk_item(FUNC_CHECK, 3, 0, 1'b1, 1001));
        pending_samples.push_back(mk_item(FUNC_CHECK, 3, 0, 1'b1, 1001));
        pending_samples.push_back(mk_item(FUNC_CHECK, 3, 4095, 1'b1, 0));
        pending_samples.push_back(mk_item(FUNC_CHECK, 3, 4095, 1'b0, 0));
        pending_samples.push_back(mk_item(FUNC_CHECK, 3, 4095, 1'b1, 0));
        pending_samples.push_back(mk_item(FUNC_CHECK, 3, 4095, 1'b1, 0));
        pending_samples.push_back(mk_item(FUNC_CHECK, 2, 2048, 1'b1, 1000));
        pending_samples.push_back(mk_item(FUNC_CHECK, 1, 0, 1'b1, 65535));
        pending_samples.push_back(mk_item(FUNC_CLEAR, 1, 0, 1'b1, 65535));
        pending_samples.push_back(mk_item(FUNC_CHECK, 0, 4095, 1'b1, 0));
        pending_samples.push_back(mk_item(FUNC_CHECK, 0, 4095, 1'b1, 0));

        // Upper data bits beyond each register's width are written and dropped.
        set_limits(16'hFFFF, 16'hF000, 16'hFFFF, 16'hFFFF);
        queue_random(125);
        calm_inputs  = 1'b1;
        calm_outputs = 1'b1;
        set_limits(0, 4095, 0, 0);
        queue_random(125);
        calm_inputs  = 1'b0;
        calm_outputs = 1'b0;
        // Long runs drive the counters up to the debounce count, where they saturate.
        set_limits(300, 60, 255, 1000);
        queue_random(400);

        for (int p = 0; p < 9; p++) begin : random_settings
            int short_v;
            int open_v;
            int deb_v;
            int min_v;
            case ($urandom_range(0, 5))
                0:       short_v = 0;
                1:       short_v = 4095;
                2:       short_v = 659;
                3:       short_v = 660;
                default: short_v = $urandom_range(50, 600);
            endcase
            case ($urandom_range(0, 4))
                0:       open_v = 0;
                1:       open_v = 4095;
                default: open_v = $urandom_range(1, 60);
            endcase
            case ($urandom_range(0, 5))
                0:       deb_v = 0;
                1:       deb_v = 1;
                2:       deb_v = 255;
                default: deb_v = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 4))
                0:       min_v = 0;
                1:       min_v = 65535;
                default: min_v = $urandom_range(0, 5000);
            endcase
            wait_drained();
            calm_inputs  = (p % 3 == 1);
            calm_outputs = (p % 3 == 1) || (p % 4 == 2);
            set_limits(short_v, open_v, deb_v, min_v);
            queue_random(125);
        end

        wait_drained();
        repeat (12) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/clfd_pkg.sv
rtl/core/channel_load_fault_detector.sv
sim/channel_load_fault_detector_tb.sv
